// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU page replacement block
// Sizes of the frame table and the fields, and the control and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int FRAMES      = 8;
   localparam int FRAME_BITS  = 3;
   localparam int PAGE_BITS   = 16;
   localparam int COUNT_BITS  = 16;
   localparam int TOTAL_BITS  = 32;
   localparam int CFG_BITS    = 4;

   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(FRAMES);

   typedef struct packed {
      logic start;    // capture a new page and restart the scan
      logic step;     // examine the frame under the scan index
      logic commit;   // update the table and load the result word
   } lfu_cmd_type;

   typedef struct packed {
      logic scan_last;   // scan index is on the last frame in use
   } lfu_status_type;

endpackage

// ===== rtl/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfu_ctrl: sequencer for the LFU page replacement block
// Accepts a request word, steps the frame scan and commits the update
// once the result register is free.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  lfu_pkg::lfu_status_type status,
   output lfu_pkg::lfu_cmd_type    cmd
);
   import lfu_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // hold until the previous result word has gone
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/lfu_dpath.sv =====
// ----------------------------------------------------------------------------
// lfu_dpath: frame table, scan registers and result register
// One frame is examined per step for a match and for the smallest count;
// the commit writes the chosen frame and builds the result word.
// ----------------------------------------------------------------------------
module lfu_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lfu_pkg::CFG_BITS-1:0]         csr_wdata,
   input  logic [lfu_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic [lfu_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  lfu_pkg::lfu_cmd_type                 cmd,
   output lfu_pkg::lfu_status_type              status
);
   import lfu_pkg::*;

   // frame table
   logic [PAGE_BITS-1:0]  page_tab_ff  [FRAMES];
   logic [COUNT_BITS-1:0] count_tab_ff [FRAMES];
   logic [FRAMES-1:0]     valid_ff;

   logic [CFG_BITS-1:0]   cfg_ff;
   logic [FRAME_BITS-1:0] last_idx;

   // scan state
   logic [FRAME_BITS-1:0] idx_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  found_ff;
   logic [FRAME_BITS-1:0] match_idx_ff;
   logic [COUNT_BITS-1:0] match_cnt_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [FRAME_BITS-1:0] best_idx_ff;
   logic                  best_valid_ff;
   logic [PAGE_BITS-1:0]  best_page_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   logic                  rd_valid;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [COUNT_BITS-1:0] rd_count;
   logic                  take_match;
   logic                  take_min;

   logic [FRAME_BITS-1:0] sel;
   logic [COUNT_BITS-1:0] hit_count;
   logic [TOTAL_BITS-1:0] total_in;
   logic                  ev_valid;
   logic [PAGE_BITS-1:0]  ev_page;

   // clamp the frame count into 1..FRAMES, kept as the last index
   always_comb begin
      if (cfg_ff == '0) begin
         last_idx = '0;
      end else if (cfg_ff > CFG_RESET) begin
         last_idx = FRAME_BITS'(FRAMES - 1);
      end else begin
         last_idx = FRAME_BITS'(cfg_ff - CFG_BITS'(1));
      end
   end

   assign status.scan_last = (idx_ff == last_idx);

   // an empty frame reads as count zero
   assign rd_valid   = valid_ff[idx_ff];
   assign rd_page    = page_tab_ff[idx_ff];
   assign rd_count   = rd_valid ? count_tab_ff[idx_ff] : '0;
   assign take_match = !found_ff && rd_valid && (rd_page == page_ff);
   assign take_min   = (idx_ff == '0) || (rd_count < best_cnt_ff);

   assign sel       = found_ff ? match_idx_ff : best_idx_ff;
   assign hit_count = (match_cnt_ff == '1) ? match_cnt_ff
                                           : match_cnt_ff + COUNT_BITS'(1);
   assign total_in  = (found_ff || total_ff == '1) ? total_ff
                                                   : total_ff + TOTAL_BITS'(1);
   assign ev_valid  = !found_ff && best_valid_ff;
   assign ev_page   = ev_valid ? best_page_ff : '0;

   assign rsp_tdata = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         valid_ff <= '0;
         total_ff <= '0;
      end else begin
         if (csr_we) begin
            cfg_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            total_ff <= total_in;
            if (!found_ff) begin
               valid_ff[sel] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff  <= req_tdata[PAGE_BITS-1:0];
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.step) begin
         idx_ff <= idx_ff + FRAME_BITS'(1);
         if (take_match) begin
            found_ff     <= 1'b1;
            match_idx_ff <= idx_ff;
            match_cnt_ff <= rd_count;
         end
         if (take_min) begin
            best_cnt_ff   <= rd_count;
            best_idx_ff   <= idx_ff;
            best_valid_ff <= rd_valid;
            best_page_ff  <= rd_page;
         end
      end
      if (cmd.commit) begin
         if (found_ff) begin
            count_tab_ff[sel] <= hit_count;
         end else begin
            page_tab_ff[sel]  <= page_ff;
            count_tab_ff[sel] <= COUNT_BITS'(1);
         end
         rsp_data_ff <= {3'b000, total_in, ev_page, ev_valid, sel, found_ff};
      end
   end

endmodule

// ===== rtl/lfu_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lfu_page_replacement: least frequently used page replacement table
// Requests are taken one at a time: the frame scan examines one frame per
// cycle over the N frames in use (N = frames in use), then the update state
// writes the table once the output register is free, and the block is ready again.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous): all frames empty, fault total zero, frame count 8.
// ----------------------------------------------------------------------------
module lfu_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lfu_pkg::CFG_BITS-1:0]      csr_wdata,   // frames_in_use
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lfu_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [15:0] page
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hit, [3:1] frame, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] fault_count, [55:53] zero
   output logic [lfu_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import lfu_pkg::*;

   lfu_cmd_type    cmd;
   lfu_status_type status;

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== rtl/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker: port level checks for the LFU page replacement block
// Watches the stream ports and the result word contents over time.
// ----------------------------------------------------------------------------
module lfu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lfu_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import lfu_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // no new request is accepted straight after an accept, while the scan runs
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");

   // a hit never reports an eviction, and no eviction means a zero page
   a_no_evict_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[20:4] == '0)
      else $error("eviction reported on a hit");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[20:5] == '0)
      else $error("evicted page not zero without an eviction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
